// ===== rtl/core/cordic_fixed_sine_defines.svh =====
// Assertion macros shared by the cordic_fixed_sine RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef CORDIC_FIXED_SINE_DEFINES_SVH
`define CORDIC_FIXED_SINE_DEFINES_SVH

// Same-cycle implication.
`define CFS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cordic_fixed_sine: same-cycle check failed");

// Next-cycle implication.
`define CFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cordic_fixed_sine: next-cycle check failed");

`endif

// ===== rtl/core/cfs_pkg.sv =====
// Package for cordic_fixed_sine: widths, CORDIC constants, arctangent table.
// No dependencies.
package cfs_pkg;

    localparam int CFS_ITER      = 16;
    localparam int ANGLE_W       = 31;
    localparam int SINE_W        = 31;
    localparam int Z_W           = 33;
    localparam int XY_W          = 32;
    localparam int TDATA_W       = 32;

    localparam logic signed [XY_W-1:0] COS_START = 32'sd326016437;
    localparam logic signed [XY_W-1:0] ONE_Q29  = 32'sd536870912;

    localparam logic signed [SINE_W-1:0] SINE_MAX = 31'sd536870912;
    localparam logic signed [SINE_W-1:0] SINE_MIN = -SINE_MAX;

    typedef logic signed [Z_W-1:0]  z_t;
    typedef logic signed [XY_W-1:0] xy_t;

    typedef struct packed {
        z_t  z;
        xy_t c;
        xy_t s;
    } cfs_vec_t;

    // atan(2^-i) in Q29
    function automatic z_t cfs_atan(input logic [3:0] idx);
        z_t r;
        case (idx)
            4'd0:    r = 33'sd421657428;
            4'd1:    r = 33'sd248918914;
            4'd2:    r = 33'sd131521918;
            4'd3:    r = 33'sd66762579;
            4'd4:    r = 33'sd33510843;
            4'd5:    r = 33'sd16771757;
            4'd6:    r = 33'sd8387925;
            4'd7:    r = 33'sd4194218;
            4'd8:    r = 33'sd2097141;
            4'd9:    r = 33'sd1048574;
            4'd10:   r = 33'sd524287;
            4'd11:   r = 33'sd262143;
            4'd12:   r = 33'sd131071;
            4'd13:   r = 33'sd65535;
            4'd14:   r = 33'sd32767;
            4'd15:   r = 33'sd16383;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/cfs_out.sv =====
// Output stage of cordic_fixed_sine: saturates the sine to +/-1.0 and holds
// the result beat for the master side. Depends on cfs_pkg.
`include "cordic_fixed_sine_defines.svh"

module cfs_out (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  cfs_pkg::xy_t             in_sine,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [cfs_pkg::TDATA_W-1:0] m_tdata   // [30:0] sine
);
    import cfs_pkg::*;

    logic                      valid_reg;
    logic                      valid_next;
    logic signed [SINE_W-1:0]  sine_reg;
    logic signed [SINE_W-1:0]  sine_next;

    assign in_ready = !valid_reg || m_tready;

    always_comb
    begin
        if (in_sine > ONE_Q29)
        begin
            sine_next = SINE_MAX;
        end
        else if (in_sine < -ONE_Q29)
        begin
            sine_next = SINE_MIN;
        end
        else
        begin
            sine_next = in_sine[SINE_W-1:0];
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            sine_reg <= sine_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(TDATA_W - SINE_W){1'b0}}, sine_reg};

    `CFS_ASSERT_NOW(a_out_range, valid_reg, (sine_reg <= SINE_MAX) && (sine_reg >= SINE_MIN))
    `CFS_ASSERT_NEXT(a_out_load, in_valid && in_ready, valid_reg)

endmodule

// ===== rtl/core/cordic_fixed_sine.sv =====
// Sine of a Q29 angle (radians, -pi/2..pi/2) by 16-step rotation-mode CORDIC,
// one iteration per register stage, then a saturating output register.
// Each accepted angle passes all stage registers and the output register; a new
// angle can be taken every cycle unless back-pressure fills the pipe. Each stage
// has its own valid bit and holds its data while the stage after it is full and
// stalled, so bubbles are squeezed out and master back-pressure stalls only as
// far as needed. Depends on cfs_pkg and cfs_out.
`include "cordic_fixed_sine_defines.svh"

module cordic_fixed_sine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cfs_pkg::TDATA_W-1:0]   s_tdata,   // [30:0] angle
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cfs_pkg::TDATA_W-1:0]   m_tdata    // [30:0] sine
);
    import cfs_pkg::*;

    logic [CFS_ITER-1:0] valid_reg;
    logic [CFS_ITER-1:0] valid_next;
    logic [CFS_ITER:0]   rdy;
    cfs_vec_t            vec_reg  [CFS_ITER];
    cfs_vec_t            vec_next [CFS_ITER];
    cfs_vec_t            vec_in;

    always_comb
    begin
        vec_in.z = Z_W'(signed'(s_tdata[ANGLE_W-1:0]));
        vec_in.c = COS_START;
        vec_in.s = '0;
    end

    genvar k;
    generate
        for (k = 0; k < CFS_ITER; k++)
        begin : g_stage
            cfs_vec_t src;
            logic     src_valid;

            if (k == 0)
            begin : g_first
                assign src       = vec_in;
                assign src_valid = s_tvalid;
            end
            else
            begin : g_rest
                assign src       = vec_reg[k-1];
                assign src_valid = valid_reg[k-1];
            end

            assign rdy[k] = !valid_reg[k] || rdy[k+1];

            always_comb
            begin
                if (src.z >= 0)
                begin
                    vec_next[k].c = src.c - (src.s >>> k);
                    vec_next[k].s = src.s + (src.c >>> k);
                    vec_next[k].z = src.z - cfs_atan(4'(k));
                end
                else
                begin
                    vec_next[k].c = src.c + (src.s >>> k);
                    vec_next[k].s = src.s - (src.c >>> k);
                    vec_next[k].z = src.z + cfs_atan(4'(k));
                end
                valid_next[k] = rdy[k] ? src_valid : valid_reg[k];
            end

            always_ff @(posedge clk)
            begin
                if (rdy[k] && src_valid)
                begin
                    vec_reg[k] <= vec_next[k];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = rdy[0];

    cfs_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid_reg[CFS_ITER-1]),
        .in_ready (rdy[CFS_ITER]),
        .in_sine  (vec_reg[CFS_ITER-1].s),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `CFS_ASSERT_NOW(a_empty_tail_ready, !valid_reg[CFS_ITER-1], s_tready)
    `CFS_ASSERT_NEXT(a_first_no_loss, valid_reg[0] && !rdy[1], valid_reg[0])
    `CFS_ASSERT_NEXT(a_tail_no_loss, valid_reg[CFS_ITER-1] && !rdy[CFS_ITER], valid_reg[CFS_ITER-1] && $stable(vec_reg[CFS_ITER-1].s))
    `CFS_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, valid_reg[0])

endmodule

// ===== dv/cordic_fixed_sine_test.sv =====
// Self-checking testbench for cordic_fixed_sine: streams Q29 angles in and
// compares every sine beat against a CORDIC predictor kept in a scoreboard.
// Depends on cfs_pkg and the cordic_fixed_sine RTL.
`timescale 1ns / 100ps

module cordic_fixed_sine_test;

    localparam int  NUM_RANDOM  = 1930;
    localparam int  QUIET_AFTER = 1750;
    localparam int  LATENCY     = 17;
    localparam int  HOLD_CYCLES = 120;
    localparam int  HOLD_AT     = 400;
    localparam int  CYCLE_LIMIT = 200000;
    localparam int  HALF_PI_Q29 = 843314857;
    localparam int  STAGES      = 16;
    localparam longint START_COS = 326016437;
    localparam longint UNIT_Q29  = 536870912;
    localparam longint ATAN_Q29 [STAGES] = '{
        421657428, 248918914, 131521918, 66762579,
        33510843, 16771757, 8387925, 4194218,
        2097141, 1048574, 524287, 262143,
        131071, 65535, 32767, 16383
    };

    class sine_board;
        logic [30:0] sine_q[$];
        int errors;
        int checked;
        int noted;
        int wide_angles;

        function logic [30:0] predict_sine(logic [30:0] angle);
            longint z;
            longint c;
            longint s;
            longint cs;
            longint ss;
            z = $signed(angle);
            c = START_COS;
            s = 0;
            for (int i = 0; i < STAGES; i++)
            begin
                cs = c >>> i;
                ss = s >>> i;
                if (z >= 0)
                begin
                    c = c - ss;
                    s = s + cs;
                    z = z - ATAN_Q29[i];
                end
                else
                begin
                    c = c + ss;
                    s = s - cs;
                    z = z + ATAN_Q29[i];
                end
            end
            if (s > UNIT_Q29)
                s = UNIT_Q29;
            if (s < -UNIT_Q29)
                s = -UNIT_Q29;
            return s[30:0];
        endfunction

        function void note_angle(logic [30:0] angle);
            int a;
            a = $signed(angle);
            if (a > HALF_PI_Q29 || a < -HALF_PI_Q29)
                wide_angles++;
            noted++;
            sine_q.push_back(predict_sine(angle));
        endfunction

        function void check_sine(logic [30:0] sine);
            logic [30:0] want;
            checked++;
            if (sine_q.size() == 0)
            begin
                errors++;
                $error("sine beat with nothing expected: actual %0d", $signed(sine));
                return;
            end
            want = sine_q.pop_front();
            if (sine !== want)
            begin
                errors++;
                $error("sine mismatch: expected %0d actual %0d", $signed(want), $signed(sine));
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    sine_board board = new();
    int  sent = 0;
    int  idle_pct = 20;
    bit  quiet = 1'b0;
    bit  held = 1'b0;
    longint cycles = 0;

    cordic_fixed_sine DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [30:0] angle
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [30:0] sine
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            board.note_angle(s_tdata[30:0]);
        if (rst_n && m_tvalid && m_tready)
            board.check_sine(m_tdata[30:0]);
    end

    // sink: random stalls, one long hold-off to back the pipe up
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && board.checked >= HOLD_AT)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (!quiet && $urandom_range(0, 99) < idle_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_angle(input logic [30:0] angle);
        if (!quiet && $urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, angle};
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
        if (sent >= QUIET_AFTER)
            quiet = 1'b1;
        @(negedge clk);
    endtask

    function automatic logic [30:0] random_angle();
        int pick;
        int a;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            a = int'($urandom_range(0, 2 * HALF_PI_Q29)) - HALF_PI_Q29;
        else if (pick < 87)
            a = $urandom();
        else if (pick < 94)
            a = int'($urandom_range(0, 64)) * (($urandom_range(0, 1) != 0) ? 1 : -1);
        else
            a = (HALF_PI_Q29 - int'($urandom_range(0, 2000)))
                * (($urandom_range(0, 1) != 0) ? 1 : -1);
        return a[30:0];
    endfunction

    initial
    begin
        logic [30:0] directed [$];
        directed = '{31'd0, 31'd1, -31'sd1, 31'd843314857, -31'sd843314857,
                     31'd843314858, -31'sd843314858, 31'h3FFFFFFF, 31'h40000000,
                     31'd421657428, -31'sd421657428, 31'd281104952, 31'd562209904,
                     31'd536870912, 31'h2AAAAAAA, 31'h55555555, 31'd8, -31'sd8,
                     31'd16383, -31'sd16383};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        idle_pct = 0;
        foreach (directed[k])
            send_angle(directed[k]);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n % 200 == 0)
                idle_pct = (n % 600 == 0) ? 0 : $urandom_range(10, 50);
            send_angle(random_angle());
        end
        s_tvalid <= 1'b0;

        while (board.sine_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);

        $display("%0d angles streamed (%0d beyond +-pi/2), %0d sine beats checked",
                 board.noted, board.wide_angles, board.checked);
        $display("random sink stalls plus one %0d-cycle hold-off, %0d errors",
                 HOLD_CYCLES, board.errors);
        if (board.errors == 0 && board.sine_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
